// ===== hw/rtl/schf_pkg.sv =====
// Shared types and constants for the strip coincidence hit filter.
package schf_pkg;

  localparam int TABLE_DEPTH         = 64;
  localparam int TABLE_AW            = $clog2(TABLE_DEPTH);
  localparam int STRIPS_PER_SIDE_DEF = 32;

  localparam int STRIP_W = 5;
  localparam int ADC_W   = 16;
  localparam int PED_W   = 20;
  localparam int SIG_W   = 16;
  localparam int CNT_W   = 6;
  localparam int PAIR_W  = 11;
  localparam int ENTRY_W = PED_W + SIG_W;
  localparam int MULT_W  = 4;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(32);

  localparam logic              MODE_RST  = 1'b0;
  localparam logic [MULT_W-1:0] SMULT_RST = MULT_W'(10);
  localparam logic [ADC_W-1:0]  FTHR_RST  = ADC_W'(300);
  localparam logic [ADC_W-1:0]  LIMIT_RST = ADC_W'(4095);
  localparam logic [ADC_W-1:0]  BAND_RST  = ADC_W'(300);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;
  localparam logic SIDE_FRONT = 1'b0;
  localparam logic SIDE_BACK  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD_MODE  = 3'd0,
    CFG_SIGMA_MULTIPLE  = 3'd1,
    CFG_FIXED_THRESHOLD = 3'd2,
    CFG_ADC_LIMIT       = 3'd3,
    CFG_BAND_OFFSET     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              threshold_mode;
    logic [MULT_W-1:0] sigma_multiple;
    logic [ADC_W-1:0]  fixed_threshold;
    logic [ADC_W-1:0]  adc_limit;
    logic [ADC_W-1:0]  band_offset;
  } cfg_t;

  // Accepted sample beat, as handed to the event stage
  typedef struct packed {
    logic               side;
    logic [STRIP_W-1:0] strip;
    logic               in_range;
    logic [ADC_W-1:0]   adc;
    logic               last;
  } samp_t;

  // Event summary at the last sample
  typedef struct packed {
    logic [CNT_W-1:0]   front_cnt;
    logic [CNT_W-1:0]   back_cnt;
    logic [STRIP_W-1:0] front_idx;
    logic [STRIP_W-1:0] back_idx;
    logic [ADC_W-1:0]   front_adc;
    logic [ADC_W-1:0]   back_adc;
  } rep_t;

  typedef struct packed {
    logic [PAIR_W-1:0]  pair_count;
    logic [STRIP_W-1:0] front_strip;
    logic [STRIP_W-1:0] back_strip;
    logic [ADC_W-1:0]   front_value;
    logic [ADC_W-1:0]   back_value;
    logic               accepted;
  } res_t;

endpackage

// ===== hw/rtl/schf_cal_mem.sv =====
// Calibration table: per-strip pedestal and sigma, registered read, valid bit per entry.
module schf_cal_mem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic                             rd_en,
  input  logic [schf_pkg::TABLE_AW-1:0]    addr,
  input  logic [schf_pkg::ENTRY_W-1:0]     wr_data,
  output logic [schf_pkg::ENTRY_W-1:0]     rd_data
);

  logic [schf_pkg::ENTRY_W-1:0]     mem [schf_pkg::TABLE_DEPTH];
  logic [schf_pkg::TABLE_DEPTH-1:0] vld_r;
  logic [schf_pkg::ENTRY_W-1:0]     rd_q_r;
  logic                             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  // never-loaded entries read as zero
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

// ===== hw/rtl/schf_evt_acc.sv =====
// Event stage: strip threshold compare, fired counts and highest hit per side.
module schf_evt_acc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  schf_pkg::cfg_t                cfg,
  input  logic                          samp_load,
  input  schf_pkg::samp_t               samp_in,
  input  logic [schf_pkg::ENTRY_W-1:0]  cal_entry,
  input  logic                          rep_take,
  output logic                          ready,
  output logic                          rep_valid,
  output schf_pkg::rep_t                rep
);

  logic                   s1_valid_r;
  schf_pkg::samp_t        s1_r;
  logic                   s1_go;
  logic                   fired;
  logic [schf_pkg::PED_W:0] lhs;
  logic [schf_pkg::PED_W:0] rhs;
  logic [schf_pkg::PED_W-1:0] ped;
  logic [schf_pkg::SIG_W-1:0] sig;

  schf_pkg::rep_t evt_r, evt_nxt;
  logic           rep_valid_r, rep_valid_nxt;
  schf_pkg::rep_t rep_r;

  assign ped = cal_entry[schf_pkg::PED_W-1:0];
  assign sig = cal_entry[schf_pkg::ENTRY_W-1:schf_pkg::PED_W];

  // 16*adc against pedestal + k*sigma, all with 4 fraction bits
  assign lhs = {1'b0, s1_r.adc, 4'b0000};
  assign rhs = (schf_pkg::PED_W+1)'(ped)
             + (schf_pkg::PED_W+1)'(cfg.sigma_multiple) * (schf_pkg::PED_W+1)'(sig);

  always_comb begin
    if (cfg.threshold_mode) begin
      fired = s1_r.in_range && (s1_r.adc > cfg.fixed_threshold);
    end else begin
      fired = s1_r.in_range && (lhs > rhs);
    end
  end

  // last beat waits while the report slot is still full
  assign s1_go = s1_valid_r && !(s1_r.last && rep_valid_r && !rep_take);
  assign ready = !s1_valid_r || s1_go;

  always_comb begin
    evt_nxt = evt_r;
    if (fired) begin
      if (s1_r.side == schf_pkg::SIDE_FRONT) begin
        if (evt_r.front_cnt == '0 || s1_r.strip >= evt_r.front_idx) begin
          evt_nxt.front_idx = s1_r.strip;
          evt_nxt.front_adc = s1_r.adc;
        end
        if (evt_r.front_cnt < schf_pkg::COUNT_CAP) begin
          evt_nxt.front_cnt = evt_r.front_cnt + 1'b1;
        end
      end else begin
        if (evt_r.back_cnt == '0 || s1_r.strip >= evt_r.back_idx) begin
          evt_nxt.back_idx = s1_r.strip;
          evt_nxt.back_adc = s1_r.adc;
        end
        if (evt_r.back_cnt < schf_pkg::COUNT_CAP) begin
          evt_nxt.back_cnt = evt_r.back_cnt + 1'b1;
        end
      end
    end
  end

  assign rep_valid_nxt = (rep_valid_r && !rep_take) || (s1_go && s1_r.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      evt_r       <= '0;
      rep_valid_r <= 1'b0;
    end else begin
      if (samp_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        evt_r <= s1_r.last ? '0 : evt_nxt;
      end
      rep_valid_r <= rep_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (samp_load) begin
      s1_r <= samp_in;
    end
    if (s1_go && s1_r.last) begin
      rep_r <= evt_nxt;
    end
  end

  assign rep_valid = rep_valid_r;
  assign rep       = rep_r;

endmodule

// ===== hw/rtl/schf_cut.sv =====
// Report stage: pair count, limit and band cuts, output register.
module schf_cut (
  input  logic            clk,
  input  logic            rst_n,
  input  schf_pkg::cfg_t  cfg,
  input  logic            rep_valid,
  input  schf_pkg::rep_t  rep,
  output logic            rep_take,
  output logic            out_valid,
  input  logic            out_ready,
  output schf_pkg::res_t  res
);

  logic                               out_valid_r;
  schf_pkg::res_t                     res_r, res_nxt;
  logic [2*schf_pkg::CNT_W-1:0]       pairs;
  logic                               has_pair;
  logic [schf_pkg::ADC_W-1:0]         fv, bv;
  logic [schf_pkg::PED_W-1:0]         f5, b5, f6, b6, off5;
  logic                               band_ok;

  assign rep_take = rep_valid && (!out_valid_r || out_ready);

  assign pairs    = rep.front_cnt * rep.back_cnt;
  assign has_pair = (pairs != '0);
  assign fv       = has_pair ? rep.front_adc : '0;
  assign bv       = has_pair ? rep.back_adc  : '0;

  // a <= 1.2*b + offset, scaled by 5 on both sides
  assign f5   = schf_pkg::PED_W'(fv) * schf_pkg::PED_W'(5);
  assign b5   = schf_pkg::PED_W'(bv) * schf_pkg::PED_W'(5);
  assign f6   = schf_pkg::PED_W'(fv) * schf_pkg::PED_W'(6);
  assign b6   = schf_pkg::PED_W'(bv) * schf_pkg::PED_W'(6);
  assign off5 = schf_pkg::PED_W'(cfg.band_offset) * schf_pkg::PED_W'(5);

  assign band_ok = (b5 <= f6 + off5) && (f5 <= b6 + off5);

  always_comb begin
    res_nxt.pair_count  = pairs[schf_pkg::PAIR_W-1:0];
    res_nxt.front_strip = has_pair ? rep.front_idx : '0;
    res_nxt.back_strip  = has_pair ? rep.back_idx  : '0;
    res_nxt.front_value = fv;
    res_nxt.back_value  = bv;
    res_nxt.accepted    = (pairs == (2*schf_pkg::CNT_W)'(1))
                          && (fv <= cfg.adc_limit) && (bv <= cfg.adc_limit)
                          && band_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rep_take || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (rep_take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/strip_coincidence_hit_filter_unit.sv =====
// Top level of the strip coincidence hit filter.
//
//  port group | dir | beat contents
//  in_*       | in  | tdata: side, strip, adc, pedestal, sigma; tuser: action; tlast: last
//  out_*      | out | tdata: pair_count, front/back strip, front/back value; tuser: accepted
//  cfg_*      | in  | register write: index, data (no read-back)
//
//  One beat per clock is taken, loads and samples alike, while in_tready is high. An event's
//  result passes, in order, the calibration read, the event update and the cut stage's output register.
//  rst_n is synchronous; it resets the valid flags, the configuration, the event and the table's valid bits,
//  so every strip reads as zero pedestal and sigma until loaded. No clearing pass.
//  A stalled output holds the last beat of an event while the report slot is full; earlier beats flow, later ones wait.
module strip_coincidence_hit_filter_unit #(
  parameter int STRIPS_PER_SIDE = schf_pkg::STRIPS_PER_SIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] side, [5:1] strip, [21:6] adc, [41:22] pedestal, [57:42] sigma
  input  logic [schf_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] action
  input  logic                                in_tuser,
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [10:0] pair_count, [15:11] front_strip, [20:16] back_strip,
  // [36:21] front_value, [52:37] back_value
  output logic [schf_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] accepted
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [schf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [schf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [schf_pkg::TABLE_AW-1:0] SIDE_OFS =
    schf_pkg::TABLE_AW'(STRIPS_PER_SIDE % schf_pkg::TABLE_DEPTH);

  schf_pkg::cfg_t  cfg_r;
  schf_pkg::samp_t samp;
  schf_pkg::rep_t  rep;
  schf_pkg::res_t  res;

  logic                              accept;
  logic                              in_range;
  logic [schf_pkg::TABLE_AW-1:0]     slot;
  logic [schf_pkg::PED_W-1:0]        in_ped;
  logic [schf_pkg::SIG_W-1:0]        in_sig;
  logic [schf_pkg::ENTRY_W-1:0]      cal_entry;
  logic                              rep_valid, rep_take;
  logic                              evt_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_mode  <= schf_pkg::MODE_RST;
      cfg_r.sigma_multiple  <= schf_pkg::SMULT_RST;
      cfg_r.fixed_threshold <= schf_pkg::FTHR_RST;
      cfg_r.adc_limit       <= schf_pkg::LIMIT_RST;
      cfg_r.band_offset     <= schf_pkg::BAND_RST;
    end else if (cfg_we) begin
      case (schf_pkg::cfg_idx_t'(cfg_index))
        schf_pkg::CFG_THRESHOLD_MODE:  cfg_r.threshold_mode  <= cfg_wdata[0];
        schf_pkg::CFG_SIGMA_MULTIPLE:  cfg_r.sigma_multiple  <=
                                         cfg_wdata[schf_pkg::MULT_W-1:0];
        schf_pkg::CFG_FIXED_THRESHOLD: cfg_r.fixed_threshold <= cfg_wdata;
        schf_pkg::CFG_ADC_LIMIT:       cfg_r.adc_limit       <= cfg_wdata;
        schf_pkg::CFG_BAND_OFFSET:     cfg_r.band_offset     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = evt_ready;
  assign accept    = in_tvalid && in_tready;

  assign samp.side  = in_tdata[0];
  assign samp.strip = in_tdata[5:1];
  assign samp.adc   = in_tdata[21:6];
  assign samp.last  = in_tlast;
  assign in_ped     = in_tdata[41:22];
  assign in_sig     = in_tdata[57:42];

  assign in_range      = (32'(samp.strip) < 32'(STRIPS_PER_SIDE));
  assign samp.in_range = in_range;

  // table slot wraps modulo the table depth
  assign slot = ((samp.side == schf_pkg::SIDE_BACK) ? SIDE_OFS : '0)
              + schf_pkg::TABLE_AW'(samp.strip);

  schf_cal_mem u_cal_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_tuser == schf_pkg::ACT_LOAD) && in_range),
    .rd_en   (accept && (in_tuser == schf_pkg::ACT_SAMPLE)),
    .addr    (slot),
    .wr_data ({in_sig, in_ped}),
    .rd_data (cal_entry)
  );

  schf_evt_acc u_evt_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .samp_load (accept && (in_tuser == schf_pkg::ACT_SAMPLE)),
    .samp_in   (samp),
    .cal_entry (cal_entry),
    .rep_take  (rep_take),
    .ready     (evt_ready),
    .rep_valid (rep_valid),
    .rep       (rep)
  );

  schf_cut u_cut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rep_valid (rep_valid),
    .rep       (rep),
    .rep_take  (rep_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {3'b000, res.back_value, res.front_value, res.back_strip,
                      res.front_strip, res.pair_count};
  assign out_tuser = res.accepted;

endmodule

// ===== test/tb_strip_coincidence_hit_filter_unit.sv =====
// Self-checking testbench for the strip coincidence hit filter: directed table, then random events.
`timescale 1ns / 1ps

module tb_strip_coincidence_hit_filter_unit;

  localparam int STRIPS      = schf_pkg::STRIPS_PER_SIDE_DEF;
  localparam int LATENCY     = 3;
  localparam int SETTLE      = LATENCY + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 36;

  typedef struct packed {
    logic                         action;
    logic                         side;
    logic [schf_pkg::STRIP_W-1:0] strip;
    logic [schf_pkg::ADC_W-1:0]   adc;
    logic [schf_pkg::PED_W-1:0]   ped;
    logic [schf_pkg::SIG_W-1:0]   sig;
    logic                         last;
  } strip_beat_t;

  typedef struct {
    strip_beat_t    beat;
    bit             typed;
    schf_pkg::res_t want;
  } directed_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [schf_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [schf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             cfg_we = 1'b0;
  logic [schf_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [schf_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // model state
  logic [schf_pkg::PED_W-1:0]   cal_ped [schf_pkg::TABLE_DEPTH];
  logic [schf_pkg::SIG_W-1:0]   cal_sig [schf_pkg::TABLE_DEPTH];
  int                           front_hits, back_hits;
  logic [schf_pkg::STRIP_W-1:0] front_idx, back_idx;
  logic [schf_pkg::ADC_W-1:0]   front_adc, back_adc;
  schf_pkg::cfg_t               active_cfg;

  schf_pkg::res_t expected_reports [$];
  directed_row_t  directed_rows [$];
  int             mismatches = 0;
  int             beats_sent = 0;
  int             cycle_count = 0;
  bit             quiet = 1'b0;

  strip_coincidence_hit_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic strip_beat_t make_beat(input int action, input int side, input int strip,
                                            input int adc, input int ped, input int sig,
                                            input int last);
    strip_beat_t b;
    b.action = 1'(action);
    b.side   = 1'(side);
    b.strip  = schf_pkg::STRIP_W'(strip);
    b.adc    = schf_pkg::ADC_W'(adc);
    b.ped    = schf_pkg::PED_W'(ped);
    b.sig    = schf_pkg::SIG_W'(sig);
    b.last   = 1'(last);
    return b;
  endfunction

  // 5*a <= 6*b + 5*offset, i.e. a not above 1.2*b + offset
  function automatic bit in_band(input logic [schf_pkg::ADC_W-1:0] a,
                                 input logic [schf_pkg::ADC_W-1:0] b);
    longint lhs, rhs;
    lhs = 5 * longint'(a);
    rhs = 6 * longint'(b) + 5 * longint'(active_cfg.band_offset);
    return lhs <= rhs;
  endfunction

  function automatic void clear_event();
    front_hits = 0;
    back_hits  = 0;
    front_idx  = '0;
    back_idx   = '0;
    front_adc  = '0;
    back_adc   = '0;
  endfunction

  task automatic filter_beat(input strip_beat_t b, output bit has_res,
                             output schf_pkg::res_t res);
    int     slot;
    int     pairs;
    bit     fired;
    longint level;
    has_res = 1'b0;
    res     = '0;
    slot    = (int'(b.side) * STRIPS + int'(b.strip)) % schf_pkg::TABLE_DEPTH;
    if (b.action == schf_pkg::ACT_LOAD) begin
      if (b.strip < STRIPS) begin
        cal_ped[slot] = b.ped;
        cal_sig[slot] = b.sig;
      end
      return;
    end
    if (b.strip < STRIPS) begin
      if (active_cfg.threshold_mode)
        fired = b.adc > active_cfg.fixed_threshold;
      else begin
        level = longint'(cal_ped[slot]) + longint'(active_cfg.sigma_multiple) *
                longint'(cal_sig[slot]);
        fired = (longint'(b.adc) * 16) > level;
      end
      if (fired && b.side == schf_pkg::SIDE_FRONT) begin
        if (front_hits == 0 || b.strip >= front_idx) begin
          front_idx = b.strip;
          front_adc = b.adc;
        end
        if (front_hits < int'(schf_pkg::COUNT_CAP)) front_hits++;
      end else if (fired) begin
        if (back_hits == 0 || b.strip >= back_idx) begin
          back_idx = b.strip;
          back_adc = b.adc;
        end
        if (back_hits < int'(schf_pkg::COUNT_CAP)) back_hits++;
      end
    end
    if (!b.last) return;
    pairs = front_hits * back_hits;
    has_res = 1'b1;
    res.pair_count = schf_pkg::PAIR_W'(pairs);
    if (pairs != 0) begin
      res.front_strip = front_idx;
      res.back_strip  = back_idx;
      res.front_value = front_adc;
      res.back_value  = back_adc;
    end
    res.accepted = (pairs == 1) && (res.front_value <= active_cfg.adc_limit) &&
                   (res.back_value <= active_cfg.adc_limit) &&
                   in_band(res.back_value, res.front_value) &&
                   in_band(res.front_value, res.back_value);
    clear_event();
  endtask

  task automatic send_beat(input strip_beat_t b, input bit typed, input schf_pkg::res_t want);
    int             gap;
    bit             has_res;
    schf_pkg::res_t res;
    gap = quiet ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, b.sig, b.ped, b.adc, b.strip, b.side};
    in_tuser  <= b.action;
    in_tlast  <= b.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_beat(b, has_res, res);
    if (has_res) expected_reports.push_back(typed ? want : res);
    beats_sent++;
  endtask

  task automatic wait_for_reports(input int settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input schf_pkg::cfg_idx_t idx,
                                input logic [schf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      schf_pkg::CFG_THRESHOLD_MODE:  active_cfg.threshold_mode  = val[0];
      schf_pkg::CFG_SIGMA_MULTIPLE:  active_cfg.sigma_multiple  = val[schf_pkg::MULT_W-1:0];
      schf_pkg::CFG_FIXED_THRESHOLD: active_cfg.fixed_threshold = val;
      schf_pkg::CFG_ADC_LIMIT:       active_cfg.adc_limit       = val;
      schf_pkg::CFG_BAND_OFFSET:     active_cfg.band_offset     = val;
      default: ;
    endcase
  endtask

  task automatic program_config(input schf_pkg::cfg_t c);
    write_register(schf_pkg::CFG_THRESHOLD_MODE, schf_pkg::CFG_DATA_W'(c.threshold_mode));
    write_register(schf_pkg::CFG_SIGMA_MULTIPLE, schf_pkg::CFG_DATA_W'(c.sigma_multiple));
    write_register(schf_pkg::CFG_FIXED_THRESHOLD, c.fixed_threshold);
    write_register(schf_pkg::CFG_ADC_LIMIT, c.adc_limit);
    write_register(schf_pkg::CFG_BAND_OFFSET, c.band_offset);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(input int action, input int side, input int strip, input int adc,
                         input int ped, input int sig, input int last, input bit typed,
                         input int pc, input int fs, input int bs, input int fv,
                         input int bv, input int acc);
    directed_row_t r;
    r.beat             = make_beat(action, side, strip, adc, ped, sig, last);
    r.typed            = typed;
    r.want.pair_count  = schf_pkg::PAIR_W'(pc);
    r.want.front_strip = schf_pkg::STRIP_W'(fs);
    r.want.back_strip  = schf_pkg::STRIP_W'(bs);
    r.want.front_value = schf_pkg::ADC_W'(fv);
    r.want.back_value  = schf_pkg::ADC_W'(bv);
    r.want.accepted    = 1'(acc);
    directed_rows.push_back(r);
  endtask

  task automatic send_plain(input strip_beat_t b);
    send_beat(b, 1'b0, '0);
  endtask

  // mostly sane calibration so that hits near a few hundred counts fire
  task automatic send_load();
    send_plain(make_beat(schf_pkg::ACT_LOAD, $urandom_range(0, 1), $urandom_range(0, 31),
                         $urandom, $urandom_range(0, 4800), $urandom_range(0, 320),
                         $urandom_range(0, 1)));
  endtask

  task automatic send_noise();
    send_plain(make_beat($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 31),
                         $urandom, $urandom, $urandom, $urandom_range(0, 1)));
  endtask

  // one front hit and mostly one back hit in correlated band, sometimes an extra hit, buried in low noise samples
  task automatic send_event();
    strip_beat_t evt [$];
    int          fa, ba;
    evt = {};
    repeat ($urandom_range(0, 3))
      evt.push_back(make_beat(schf_pkg::ACT_SAMPLE, $urandom_range(0, 1),
                              $urandom_range(0, 31), $urandom_range(0, 40), 0, 0, 0));
    fa = $urandom_range(0, 4600);
    ba = fa + $urandom_range(0, 1200) - 600;
    if (ba < 0) ba = 0;
    evt.insert($urandom_range(0, evt.size()),
               make_beat(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, $urandom_range(0, 31),
                         fa, 0, 0, 0));
    if ($urandom_range(0, 9) != 0)
      evt.insert($urandom_range(0, evt.size()),
                 make_beat(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, $urandom_range(0, 31),
                           ba, 0, 0, 0));
    if ($urandom_range(0, 4) == 0)
      evt.insert($urandom_range(0, evt.size()),
                 make_beat(schf_pkg::ACT_SAMPLE, $urandom_range(0, 1), $urandom_range(0, 31),
                           $urandom_range(0, 4600), 0, 0, 0));
    evt[evt.size()-1].last = 1'b1;
    foreach (evt[i]) send_plain(evt[i]);
  endtask

  // enough hits on both sides to hit the count ceiling
  task automatic send_long_event();
    strip_beat_t b;
    for (int i = 0; i < 80; i++) begin
      b = make_beat(schf_pkg::ACT_SAMPLE, i >= 40, $urandom_range(0, 31),
                    $urandom_range(30000, 65535), 0, 0, i == 79);
      send_plain(b);
    end
  endtask

  always @(posedge clk) begin : report_check
    schf_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %h / %b", $time,
                 out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (want.pair_count != out_tdata[10:0] || want.front_strip != out_tdata[15:11] ||
            want.back_strip != out_tdata[20:16] || want.front_value != out_tdata[36:21] ||
            want.back_value != out_tdata[52:37] || want.accepted != out_tuser) begin
          $display("%0t: result mismatch: expected pairs %0d front %0d/%0d back %0d/%0d acc %0d",
                   $time, want.pair_count, want.front_strip, want.front_value,
                   want.back_strip, want.back_value, want.accepted);
          $display("%0t:                  actual   pairs %0d front %0d/%0d back %0d/%0d acc %0d",
                   $time, out_tdata[10:0], out_tdata[15:11], out_tdata[36:21],
                   out_tdata[20:16], out_tdata[52:37], out_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    forever begin
      @(negedge clk);
      stall = quiet ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    schf_pkg::cfg_t c;
    int             start;
    foreach (cal_ped[i]) begin
      cal_ped[i] = '0;
      cal_sig[i] = '0;
    end
    clear_event();
    active_cfg.threshold_mode  = schf_pkg::MODE_RST;
    active_cfg.sigma_multiple  = schf_pkg::SMULT_RST;
    active_cfg.fixed_threshold = schf_pkg::FTHR_RST;
    active_cfg.adc_limit       = schf_pkg::LIMIT_RST;
    active_cfg.band_offset     = schf_pkg::BAND_RST;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: pedestal+sigma mode, 10 sigma, threshold at adc > 120 for loaded strips
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 31, 65535, 0, 0, 1, 1,
            0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_LOAD, schf_pkg::SIDE_FRONT, 5, 0, 1600, 32, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_LOAD, schf_pkg::SIDE_BACK, 7, 0, 1600, 32, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_LOAD, schf_pkg::SIDE_FRONT, 31, 65535, 1048575, 65535, 1, 0,
            0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_LOAD, schf_pkg::SIDE_BACK, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 5, 500, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 7, 520, 0, 0, 1, 1,
            1, 5, 7, 500, 520, 1);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 31, 65535, 0, 0, 0, 0,
            0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 31, 1, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0);
    // same strip twice: counts twice, later ADC wins
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 5, 200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 5, 300, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 7, 300, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    // lower strip after a higher one keeps the higher index
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 5, 400, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 4, 4000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 7, 400, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    // band cut fails, then limit cut fails
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 5, 2000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 7, 4000, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 5, 5000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 7, 5000, 0, 0, 1, 1,
            1, 5, 7, 5000, 5000, 0);
    // just at and just above the per-strip threshold
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_FRONT, 5, 120, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 7, 120, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(schf_pkg::ACT_SAMPLE, schf_pkg::SIDE_BACK, 7, 121, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1: c = '{threshold_mode: 1'b0, sigma_multiple: 4'd0, fixed_threshold: 16'd0,
                 adc_limit: 16'hFFFF, band_offset: 16'd0};
        2: c = '{threshold_mode: 1'b0, sigma_multiple: 4'd15, fixed_threshold: 16'hFFFF,
                 adc_limit: 16'd0, band_offset: 16'hFFFF};
        3: c = '{threshold_mode: 1'b1, sigma_multiple: 4'd7, fixed_threshold: 16'd0,
                 adc_limit: 16'hFFFF, band_offset: 16'hFFFF};
        4: c = '{threshold_mode: 1'b1, sigma_multiple: 4'd10, fixed_threshold: 16'hFFFF,
                 adc_limit: 16'd4095, band_offset: 16'd300};
        default: begin
          c.threshold_mode  = 1'($urandom_range(0, 1));
          c.sigma_multiple  = schf_pkg::MULT_W'($urandom_range(0, 15));
          c.fixed_threshold = schf_pkg::ADC_W'($urandom_range(0, 2000));
          c.adc_limit       = schf_pkg::ADC_W'($urandom_range(1000, 65535));
          c.band_offset     = schf_pkg::ADC_W'($urandom_range(0, 1000));
        end
      endcase
      wait_for_reports(SETTLE);
      program_config(c);
      quiet = (ph == 2) || (ph == 6);
      start = beats_sent;
      repeat (6) send_load();
      if (ph == 3) send_long_event();
      while (beats_sent - start < PHASE_BEATS) begin
        case ($urandom_range(0, 9))
          0:       send_noise();
          1:       send_load();
          default: send_event();
        endcase
        // in phase 5, after each send in a mid-phase window, hold the sender until the output side has caught up
        if (ph == 5 && beats_sent - start >= PHASE_BEATS / 2 &&
            beats_sent - start < PHASE_BEATS / 2 + 8)
          wait_for_reports(0);
      end
    end

    wait_for_reports(SETTLE);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== strip_coincidence_hit_filter_unit.f =====
hw/rtl/schf_pkg.sv
hw/rtl/schf_cal_mem.sv
hw/rtl/schf_evt_acc.sv
hw/rtl/schf_cut.sv
hw/rtl/strip_coincidence_hit_filter_unit.sv
test/tb_strip_coincidence_hit_filter_unit.sv
